### design/lmr_pkg.sv
// ----------------------------------------------------------------------------
// lmr_pkg
// Shared types, constants and helpers of the learning message router.
// ----------------------------------------------------------------------------
`default_nettype none

package lmr_pkg;

  // channel count, forward mask width and field widths
  localparam int NUM_CHANNELS = 4;
  localparam int CHAN_W       = 4;
  localparam int ID_W         = 8;
  localparam int TGT_W        = 9;
  localparam int CH_W         = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  // configuration reset values
  localparam logic [ID_W-1:0]   OWN_SYSTEM_RESET    = 8'd200;
  localparam logic [ID_W-1:0]   OWN_COMPONENT_RESET = 8'd1;
  localparam logic [CHAN_W-1:0] ACTIVE_RESET        = 4'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_SYSTEM      = 2'd0,
    CFG_OWN_COMPONENT   = 2'd1,
    CFG_ACTIVE_CHANNELS = 2'd2
  } cfg_index_t;

  // one message descriptor
  typedef struct packed {
    logic                    from_local;
    logic [CH_W-1:0]         origin_channel;
    logic [ID_W-1:0]         source_system;
    logic [ID_W-1:0]         source_component;
    logic                    heartbeat_flag;
    logic signed [TGT_W-1:0] target_system;
    logic signed [TGT_W-1:0] target_component;
  } query_t;

  // item walking down the cell chain with its partial results
  typedef struct packed {
    logic              valid;
    query_t            q;
    logic [CHAN_W-1:0] mask;
    logic              dup;
  } token_t;

  // one route table entry
  typedef struct packed {
    logic [ID_W-1:0] system;
    logic [ID_W-1:0] component;
    logic [CH_W-1:0] channel;
  } entry_t;

  // channels that exist
  function automatic logic [CHAN_W-1:0] chan_mask();
    logic [CHAN_W-1:0] m;
    m = '0;
    for (int i = 0; i < CHAN_W; i++) begin
      m[i] = (i < NUM_CHANNELS);
    end
    return m;
  endfunction

  // one-hot bit of a channel, zero for a channel that does not exist
  function automatic logic [CHAN_W-1:0] chan_bit(input logic [CH_W-1:0] ch);
    logic [CHAN_W-1:0] b;
    b = '0;
    if (int'(ch) < NUM_CHANNELS) begin
      b[ch] = 1'b1;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### design/lmr_in_if.sv
// ----------------------------------------------------------------------------
// lmr_in_if
// Message descriptor channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 from_local;
  logic [lmr_pkg::CH_W-1:0]             origin_channel;
  logic [lmr_pkg::ID_W-1:0]             source_system;
  logic [lmr_pkg::ID_W-1:0]             source_component;
  logic                                 heartbeat_flag;
  logic signed [lmr_pkg::TGT_W-1:0]     target_system;
  logic signed [lmr_pkg::TGT_W-1:0]     target_component;

  modport source (
    output valid, from_local, origin_channel, source_system, source_component,
           heartbeat_flag, target_system, target_component,
    input  ready
  );

  modport sink (
    input  valid, from_local, origin_channel, source_system, source_component,
           heartbeat_flag, target_system, target_component,
    output ready
  );
endinterface

`default_nettype wire

### design/lmr_out_if.sv
// ----------------------------------------------------------------------------
// lmr_out_if
// Routing result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmr_out_if;
  logic                           valid;
  logic                           ready;
  logic [lmr_pkg::CHAN_W-1:0]     forward_mask;
  logic                           for_self;
  logic                           route_learned;

  modport source (
    output valid, forward_mask, for_self, route_learned,
    input  ready
  );

  modport sink (
    input  valid, forward_mask, for_self, route_learned,
    output ready
  );
endinterface

`default_nettype wire

### design/learning_message_router.sv
// ----------------------------------------------------------------------------
// learning_message_router
// Learns (system, component, channel) routes and computes forward masks.
// ----------------------------------------------------------------------------
// Each accepted item walks a row of MAX_ROUTES cells, one cell per cycle
// while the row is not held; every cell holds one route entry, adds its
// channel to the mask on a target match and adds its duplicate check to
// the item. The next item is taken only once the current one has left
// the row into the output register. A new route is written into the next
// free cell when the item leaves the row. A finished result waits in the
// output register while the next item is already walking the row; if it
// is still waiting when that item reaches the end of the row, the row
// holds until the receiver takes it.
`default_nettype none

module learning_message_router #(
  parameter int MAX_ROUTES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  lmr_in_if.sink                                 msg,
  lmr_out_if.source                              route,
  input  wire logic                              cfg_we,
  input  wire logic [lmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lmr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);

  logic [lmr_pkg::ID_W-1:0]   own_system_id;
  logic [lmr_pkg::ID_W-1:0]   own_component_id;
  logic [lmr_pkg::CHAN_W-1:0] active_channels;
  logic [CNT_W-1:0]           entry_count;
  logic                       busy;

  lmr_pkg::token_t chain [MAX_ROUTES+1];
  lmr_pkg::token_t tail;
  lmr_pkg::entry_t wr_entry;
  logic            accept;
  logic            out_free;
  logic            done;
  logic            adv;
  logic            skip_learn;
  logic            learn;
  logic            is_self;
  logic [lmr_pkg::CHAN_W-1:0] mask_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_system_id    <= lmr_pkg::OWN_SYSTEM_RESET;
      own_component_id <= lmr_pkg::OWN_COMPONENT_RESET;
      active_channels  <= lmr_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lmr_pkg::CFG_OWN_SYSTEM:      own_system_id    <= cfg_data;
        lmr_pkg::CFG_OWN_COMPONENT:   own_component_id <= cfg_data;
        lmr_pkg::CFG_ACTIVE_CHANNELS: active_channels  <= cfg_data[lmr_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign msg.ready = !busy;
  assign accept    = msg.valid && !busy;
  assign tail      = chain[MAX_ROUTES];
  assign out_free  = !route.valid || route.ready;
  assign done      = tail.valid && out_free;
  assign adv       = !tail.valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // head of the chain
  always_comb begin
    chain[0].valid              = accept;
    chain[0].q.from_local       = msg.from_local;
    chain[0].q.origin_channel   = msg.origin_channel;
    chain[0].q.source_system    = msg.source_system;
    chain[0].q.source_component = msg.source_component;
    chain[0].q.heartbeat_flag   = msg.heartbeat_flag;
    chain[0].q.target_system    = msg.target_system;
    chain[0].q.target_component = msg.target_component;
    chain[0].mask               = '0;
    chain[0].dup                = 1'b0;
  end

  // row of route cells
  for (genvar k = 0; k < MAX_ROUTES; k++) begin : g_cell
    lmr_cell #(
      .INDEX (k),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .wr_en    (done && learn),
      .wr_idx   (entry_count[IDX_W-1:0]),
      .wr_entry (wr_entry),
      .tok_in   (chain[k]),
      .tok_out  (chain[k+1])
    );
  end

  // learning decision and final mask at the end of the row
  always_comb begin
    wr_entry.system    = tail.q.source_system;
    wr_entry.component = tail.q.source_component;
    wr_entry.channel   = tail.q.origin_channel;
    skip_learn = (tail.q.source_system == '0) ||
                 ((tail.q.source_system == own_system_id) &&
                  (tail.q.source_component == own_component_id));
    learn = !tail.q.from_local && !skip_learn && !tail.dup &&
            (entry_count < CNT_W'(MAX_ROUTES));
    is_self = (tail.q.target_system == $signed({1'b0, own_system_id})) &&
              (tail.q.target_component == $signed({1'b0, own_component_id}));
    if (tail.q.heartbeat_flag) begin
      mask_next = active_channels & lmr_pkg::chan_mask();
      if (!tail.q.from_local) begin
        mask_next = mask_next & ~lmr_pkg::chan_bit(tail.q.origin_channel);
      end
    end else if (is_self) begin
      mask_next = '0;
    end else begin
      mask_next = tail.mask;
    end
  end

  // table fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (done && learn) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      route.valid <= 1'b0;
    end else if (done) begin
      route.valid <= 1'b1;
    end else if (route.ready) begin
      route.valid <= 1'b0;
    end
    if (done) begin
      route.forward_mask  <= mask_next;
      route.for_self      <= !tail.q.heartbeat_flag && is_self;
      route.route_learned <= learn;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ROUTES))
    else $error("route count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (done && learn) |=> (entry_count == $past(entry_count) + CNT_W'(1)))
    else $error("route count did not advance on learn");

  a_tail_busy: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> busy)
    else $error("item in cell row while idle");

  a_self_mask: assert property (@(posedge clk) disable iff (rst)
    (route.valid && route.for_self) |-> (route.forward_mask == '0))
    else $error("item for this node has a forward mask");

endmodule

`default_nettype wire

### design/lmr_cell.sv
// ----------------------------------------------------------------------------
// lmr_cell
// One route table slot: holds an entry, checks the passing item against it
// and hands the item to the next cell through a register that holds while adv is low.
// ----------------------------------------------------------------------------
`default_nettype none

module lmr_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic                wr_en,
  input  wire logic [IDX_W-1:0]    wr_idx,
  input  wire lmr_pkg::entry_t     wr_entry,
  input  wire lmr_pkg::token_t     tok_in,
  output lmr_pkg::token_t          tok_out
);

  lmr_pkg::entry_t entry;
  logic            entry_valid;
  lmr_pkg::token_t tok_next;
  logic            tsys_any;
  logic            tcomp_any;
  logic            sys_eq;
  logic            comp_eq;
  logic            hit;
  logic            dup;

  // entry storage, filled once in table order
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (wr_en && wr_idx == IDX_W'(INDEX)) begin
      entry_valid <= 1'b1;
    end
    if (wr_en && wr_idx == IDX_W'(INDEX)) begin
      entry <= wr_entry;
    end
  end

  // target match against this entry
  always_comb begin
    tsys_any  = tok_in.q.target_system[lmr_pkg::TGT_W-1] || (tok_in.q.target_system == '0);
    tcomp_any = tok_in.q.target_component[lmr_pkg::TGT_W-1] ||
                (tok_in.q.target_component == '0);
    sys_eq    = !tok_in.q.target_system[lmr_pkg::TGT_W-1] &&
                (tok_in.q.target_system[lmr_pkg::ID_W-1:0] == entry.system);
    comp_eq   = !tok_in.q.target_component[lmr_pkg::TGT_W-1] &&
                (tok_in.q.target_component[lmr_pkg::ID_W-1:0] == entry.component);
    hit       = entry_valid && (tsys_any || (sys_eq && (tcomp_any || comp_eq)));
    dup       = entry_valid &&
                (entry.system == tok_in.q.source_system) &&
                (entry.component == tok_in.q.source_component) &&
                (entry.channel == tok_in.q.origin_channel);
  end

  // accumulate mask and duplicate flag
  always_comb begin
    tok_next = tok_in;
    if (hit && (tok_in.q.from_local || entry.channel != tok_in.q.origin_channel)) begin
      tok_next.mask = tok_in.mask | lmr_pkg::chan_bit(entry.channel);
    end
    tok_next.dup = tok_in.dup | dup;
  end

  // hand the item to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out.valid <= tok_next.valid;
    end
    if (adv) begin
      tok_out.q    <= tok_next.q;
      tok_out.mask <= tok_next.mask;
      tok_out.dup  <= tok_next.dup;
    end
  end

endmodule

`default_nettype wire
